[hw/rtl/afl_pkg.sv]
// ----------------------------------------------------------------------------
// afl_pkg
// Shared types and constants of the flanger delay block: controller states,
// controller to datapath command and status groups, field widths and
// configuration register indexes.
// ----------------------------------------------------------------------------
package afl_pkg;

    // fixed field widths
    localparam int PHASE_BITS = 24;
    localparam int MIX_BITS   = 16;
    localparam int RANGE_BITS = 13;
    localparam int STEP_BITS  = 20;
    localparam int CFG_DATA_BITS = 20;
    localparam int CFG_IDX_BITS  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIX_RATIO   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SWEEP_RANGE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP  = 2'd2;

    // register values after reset
    localparam logic [MIX_BITS-1:0]   MIX_RATIO_RST   = 16'd19661;
    localparam logic [RANGE_BITS-1:0] SWEEP_RANGE_RST = 13'd1000;
    localparam logic [STEP_BITS-1:0]  PHASE_STEP_RST  = 20'd77;

    // divider produces one quotient bit per step; the quotient stays below 2^RANGE_BITS
    localparam int DIV_STEPS = RANGE_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K,
        ST_P,
        ST_NUM,
        ST_DIV,
        ST_READ,
        ST_MIX,
        ST_DONE
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic calc_k;
        logic calc_p;
        logic load_div;
        logic div_step;
        logic rd_mem;
        logic mix;
        logic load_out;
    } afl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } afl_status_t;

endpackage

[hw/rtl/afl_ctrl.sv]
// ----------------------------------------------------------------------------
// afl_ctrl
// Controller of the flanger delay block: steps one sample through sine
// product, numerator, bit-serial division, delay line read, mix and output.
// ----------------------------------------------------------------------------
module afl_ctrl
    import afl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  afl_status_t status,
    output afl_cmd_t    cmd
);

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_K;
                end
            end
            ST_K:
            begin
                cmd.calc_k = 1'b1;
                state_next = ST_P;
            end
            ST_P:
            begin
                cmd.calc_p = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.load_div = 1'b1;
                div_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_mem = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/afl_datapath.sv]
// ----------------------------------------------------------------------------
// afl_datapath
// Datapath of the flanger delay block: sweep phase, sine product, restoring
// divider for the delay, ring delay line memory, dry/wet mix and output
// register.
// ----------------------------------------------------------------------------
module afl_datapath
    import afl_pkg::*;
#(
    parameter int DELAY_DEPTH      = 4096,
    parameter int SAMPLE_BITS      = 12,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  afl_cmd_t               cmd,
    output afl_status_t            status,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  logic [MIX_BITS-1:0]    mix_ratio,
    input  logic [RANGE_BITS-1:0]  sweep_range,
    input  logic [STEP_BITS-1:0]   phase_step,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] sample_out
);

    localparam int AW       = $clog2(DELAY_DEPTH);
    localparam int KW       = $clog2(SINE_TABLE_DEPTH);
    localparam int KPW      = PHASE_BITS + KW + 1;
    localparam int P_W      = 2 * KW + 1;
    localparam int DEN_BASE = 5 * SINE_TABLE_DEPTH * SINE_TABLE_DEPTH;
    localparam int DEN_W    = $clog2(DEN_BASE + 1);
    localparam int NUM_W    = P_W + RANGE_BITS + 3;
    localparam int Q_W      = DIV_STEPS;
    localparam int RW       = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
    localparam int CW       = (Q_W > AW + 1) ? Q_W : AW + 1;
    localparam int MW       = SAMPLE_BITS + MIX_BITS + 2;

    // sweep state and delay line pointer
    logic [PHASE_BITS-1:0]  phase_reg;
    logic                   down_reg;
    logic [AW-1:0]          wr_pos_reg;
    logic                   wrapped_reg;

    // per-sample working registers
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [KW-1:0]          k_reg;
    logic [P_W-1:0]         p_reg;
    logic [RW-1:0]          rem_reg;
    logic [RW-1:0]          den_sh_reg;
    logic [Q_W-1:0]         q_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic                   zero_d_reg;
    logic [SAMPLE_BITS-1:0] mixed_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_out_reg;

    logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

    // phase advance
    logic [PHASE_BITS:0]    phase_sum;
    logic [PHASE_BITS-1:0]  phase_next;
    logic                   down_next;

    always_comb
    begin
        phase_sum  = {1'b0, phase_reg} + (PHASE_BITS+1)'(phase_step);
        phase_next = phase_reg;
        down_next  = down_reg;
        if (!down_reg)
        begin
            if (phase_sum[PHASE_BITS])
            begin
                phase_next = '1;
                down_next  = 1'b1;
            end
            else
            begin
                phase_next = phase_sum[PHASE_BITS-1:0];
            end
        end
        else
        begin
            if (phase_reg <= PHASE_BITS'(phase_step))
            begin
                phase_next = '0;
                down_next  = 1'b0;
            end
            else
            begin
                phase_next = phase_reg - PHASE_BITS'(phase_step);
            end
        end
    end

    // sine table index, product and division operands
    logic [KPW-1:0]   k_prod;
    logic [KW:0]      k_comp;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;

    always_comb
    begin
        k_prod = KPW'(phase_reg) * KPW'(SINE_TABLE_DEPTH);
        k_comp = (KW+1)'(SINE_TABLE_DEPTH) - {1'b0, k_reg};
        num    = (NUM_W'(p_reg) * NUM_W'(sweep_range)) << 3;
        den    = DEN_W'(DEN_BASE) - DEN_W'({p_reg, 2'b00});
    end

    // restoring division step
    logic           div_ge;
    logic [RW-1:0]  rem_sub;

    always_comb
    begin
        div_ge  = rem_reg >= den_sh_reg;
        rem_sub = rem_reg - den_sh_reg;
    end

    // delay clamp and read address
    logic [CW-1:0]  q_ext;
    logic [AW-1:0]  delay;
    logic [AW:0]    addr_sum;
    logic [AW-1:0]  rd_addr;

    always_comb
    begin
        q_ext = CW'(q_reg);
        if (q_ext > CW'(DELAY_DEPTH - 1))
        begin
            delay = AW'(DELAY_DEPTH - 1);
        end
        else
        begin
            delay = q_ext[AW-1:0];
        end
        addr_sum = (AW+1)'(wr_pos_reg) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(delay);
        if (addr_sum >= (AW+1)'(DELAY_DEPTH))
        begin
            addr_sum = addr_sum - (AW+1)'(DELAY_DEPTH);
        end
        rd_addr = addr_sum[AW-1:0];
    end

    // mix: delayed + ratio * (dry - delayed), scaled down by 2^16
    logic [SAMPLE_BITS-1:0]    delayed;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [MIX_BITS:0]  ratio_s;
    logic signed [MW-1:0]      mix_prod;
    logic signed [MW-1:0]      mix_acc;

    always_comb
    begin
        if (zero_d_reg)
        begin
            delayed = sample_reg;
        end
        else if (rd_valid_reg)
        begin
            delayed = rd_data_reg;
        end
        else
        begin
            delayed = '0;
        end
        diff     = $signed({1'b0, sample_reg}) - $signed({1'b0, delayed});
        ratio_s  = $signed({1'b0, mix_ratio});
        mix_prod = MW'(ratio_s) * MW'(diff);
        mix_acc  = $signed({2'b00, delayed, {MIX_BITS{1'b0}}}) + mix_prod;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            down_reg      <= 1'b0;
            wr_pos_reg    <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                down_reg  <= down_next;
            end
            if (cmd.mix)
            begin
                if (wr_pos_reg == AW'(DELAY_DEPTH - 1))
                begin
                    wr_pos_reg  <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wr_pos_reg <= wr_pos_reg + 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample_in;
        end
        if (cmd.calc_k)
        begin
            k_reg <= k_prod[PHASE_BITS +: KW];
        end
        if (cmd.calc_p)
        begin
            p_reg <= P_W'(k_reg) * P_W'(k_comp);
        end
        if (cmd.load_div)
        begin
            rem_reg    <= RW'(num);
            den_sh_reg <= RW'(den) << (Q_W - 1);
            q_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_sub;
            end
            den_sh_reg <= den_sh_reg >> 1;
            q_reg      <= {q_reg[Q_W-2:0], div_ge};
        end
        if (cmd.rd_mem)
        begin
            // entries never written since reset read as zero
            rd_valid_reg <= wrapped_reg || (rd_addr < wr_pos_reg);
            zero_d_reg   <= (delay == '0);
        end
        if (cmd.mix)
        begin
            mixed_reg <= mix_acc[MIX_BITS +: SAMPLE_BITS];
        end
        if (cmd.load_out)
        begin
            sample_out_reg <= mixed_reg;
        end
    end

    // delay line memory
    always_ff @(posedge clk)
    begin
        if (cmd.mix)
        begin
            mem[wr_pos_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_mem)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_out_reg;

endmodule

[hw/rtl/audio_flanger_delay_top.sv]
// ----------------------------------------------------------------------------
// audio_flanger_delay_top
// Flanger on a modulated ring delay line: a triangle sweep over 0..pi drives
// a sine-shaped delay, and the dry sample is mixed with the delayed one.
//
//   channel   signals                          direction   payload
//   in        in_valid / in_ready              sink        sample_in
//   out       out_valid / out_ready            source      sample_out
//   cfg       cfg_valid / cfg_ready            sink        cfg_index, cfg_data
//
// One sample at a time, in the steps idle, index, product, numerator, 13
// divider steps, memory read, mix and output load; no new sample is taken
// before the last one reaches the output load.
// The output register lets the next sample be taken while a result waits.
// Reset clears the sweep, write pointer and output valid; delay line entries
// not yet written read as zero, so no clearing pass is needed.
// cfg_ready is always high; writes are expected only while idle.
// ----------------------------------------------------------------------------
module audio_flanger_delay_top
    import afl_pkg::*;
#(
    parameter int DELAY_DEPTH      = 4096,
    parameter int SAMPLE_BITS      = 12,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SAMPLE_BITS-1:0]   sample_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [SAMPLE_BITS-1:0]   sample_out,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [MIX_BITS-1:0]   mix_ratio_reg;
    logic [RANGE_BITS-1:0] sweep_range_reg;
    logic [STEP_BITS-1:0]  phase_step_reg;

    afl_cmd_t    cmd;
    afl_status_t status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_ratio_reg   <= MIX_RATIO_RST;
            sweep_range_reg <= SWEEP_RANGE_RST;
            phase_step_reg  <= PHASE_STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIX_RATIO:   mix_ratio_reg   <= cfg_data[MIX_BITS-1:0];
                CFG_SWEEP_RANGE: sweep_range_reg <= cfg_data[RANGE_BITS-1:0];
                CFG_PHASE_STEP:  phase_step_reg  <= cfg_data[STEP_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // sequencer
    afl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    afl_datapath #(
        .DELAY_DEPTH      (DELAY_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample_in   (sample_in),
        .mix_ratio   (mix_ratio_reg),
        .sweep_range (sweep_range_reg),
        .phase_step  (phase_step_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out)
    );

endmodule

[hw/rtl/afl_checker.sv]
// ----------------------------------------------------------------------------
// afl_checker
// Port-level checks of the flanger delay block, bound to the top level.
// ----------------------------------------------------------------------------
module afl_checker
#(
    parameter int SAMPLE_BITS = 12
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] sample_out,
    input logic                   cfg_ready
);

    // a pending result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before transaction");

    // a pending result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample_out))
        else $error("sample_out changed while stalled");

    // block stays busy, with in_ready low, after taking a sample
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("in_ready returned too early");

    // a new result only appears at the end of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work in progress");

    // configuration port never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready low");

endmodule

bind audio_flanger_delay_top afl_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_afl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_ready  (cfg_ready)
);

[dv/tb_audio_flanger_delay_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_audio_flanger_delay_top
// Self-checking bench for the flanger delay block. A clocked driver feeds
// samples from a pending queue and a clocked monitor predicts each mixed
// sample as the input transaction is taken: triangle sweep, Bhaskara sine
// delay, ring read and dry/wet mix. Results are compared in order. Both
// channels idle at random, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_audio_flanger_delay_top;
    import afl_pkg::*;

    localparam int RING_DEPTH  = 4096;
    localparam int SAMPLE_W    = 12;
    localparam int SINE_DEPTH  = 1024;
    localparam int TAIL_CYCLES = 30;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 48;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam logic [SAMPLE_W-1:0]     SAMPLE_MAX = '1;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [SAMPLE_W-1:0]      sample_in = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [SAMPLE_W-1:0]      sample_out;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    audio_flanger_delay_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // mirror of the block state and registers
    logic [SAMPLE_W-1:0]   ring_mem [RING_DEPTH];
    int unsigned           ring_wr = 0;
    logic [PHASE_BITS-1:0] sweep_ph = '0;
    logic                  sweep_falling = 1'b0;
    logic [MIX_BITS-1:0]   dry_weight = MIX_RATIO_RST;
    logic [RANGE_BITS-1:0] sweep_span = SWEEP_RANGE_RST;
    logic [STEP_BITS-1:0]  sweep_inc = PHASE_STEP_RST;

    logic [SAMPLE_W-1:0] samples_pending [$];
    logic [SAMPLE_W-1:0] flanged_due [$];
    int n_queued = 0;
    int n_taken = 0;
    int n_err = 0;
    bit in_idle_en = 1'b1;
    bit out_idle_en = 1'b1;

    initial begin
        for (int i = 0; i < RING_DEPTH; i++)
            ring_mem[i] = '0;
    end

    function automatic int gap_draw(input bit en);
        return en ? int'($urandom_range(0, 13)) : 0;
    endfunction

    // register write as the block sees it; bits above the width are dropped
    function automatic void reg_apply(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_MIX_RATIO:   dry_weight = data[MIX_BITS-1:0];
            CFG_SWEEP_RANGE: sweep_span = data[RANGE_BITS-1:0];
            CFG_PHASE_STEP:  sweep_inc  = data[STEP_BITS-1:0];
            default: ;
        endcase
    endfunction

    // advance the sweep, derive the delay, mix, then store the new sample
    function automatic logic [SAMPLE_W-1:0] flange_mix(input logic [SAMPLE_W-1:0] s);
        longint unsigned sum, k, p, den, d, acc;
        logic [SAMPLE_W-1:0] delayed;
        sum = longint'(sweep_ph) + longint'(sweep_inc);
        if (!sweep_falling) begin
            // top of sweep: saturate just below pi and turn round
            if (sum >= (64'd1 << PHASE_BITS)) begin
                sweep_ph = '1;
                sweep_falling = 1'b1;
            end else begin
                sweep_ph = sum[PHASE_BITS-1:0];
            end
        end else if (sweep_ph <= sweep_inc) begin
            sweep_ph = '0;
            sweep_falling = 1'b0;
        end else begin
            sweep_ph = sweep_ph - sweep_inc;
        end
        k = (longint'(sweep_ph) * SINE_DEPTH) >> PHASE_BITS;
        if (k >= SINE_DEPTH)
            k = SINE_DEPTH - 1;
        p = k * (SINE_DEPTH - k);
        den = 5 * SINE_DEPTH * SINE_DEPTH - 4 * p;
        d = (8 * p * longint'(sweep_span)) / den;
        if (d > RING_DEPTH - 1)
            d = RING_DEPTH - 1;
        if (d == 0)
            delayed = s;
        else
            delayed = ring_mem[(ring_wr + RING_DEPTH - int'(d)) % RING_DEPTH];
        acc = longint'(dry_weight) * s + (65536 - longint'(dry_weight)) * delayed;
        ring_mem[ring_wr] = s;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        return acc[16 +: SAMPLE_W];
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n) begin : sample_drv
        int gap;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            sample_in <= '0;
            gap = 0;
        end else if (!in_valid || in_ready) begin
            if (gap > 0) begin
                in_valid <= 1'b0;
                gap = gap - 1;
            end else if (samples_pending.size() > 0) begin
                in_valid  <= 1'b1;
                sample_in <= samples_pending.pop_front();
                gap = gap_draw(in_idle_en);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(posedge clk or negedge rst_n) begin : result_stall
        int hold;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold = 0;
        end else if (out_ready && out_valid) begin
            hold = gap_draw(out_idle_en);
            out_ready <= (hold == 0);
        end else if (!out_ready) begin
            if (hold <= 1)
                out_ready <= 1'b1;
            if (hold > 0)
                hold = hold - 1;
        end
    end

    // monitor: register writes, input transactions and result checks
    always @(posedge clk) begin : monitor
        logic [SAMPLE_W-1:0] want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (flanged_due.size() == 0) begin
                    $error("sample_out unexpected: expected none, actual %0d", sample_out);
                    n_err++;
                end else begin
                    want = flanged_due.pop_front();
                    if (sample_out !== want) begin
                        $error("sample_out mismatch: expected %0d, actual %0d", want, sample_out);
                        n_err++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                reg_apply(cfg_index, cfg_data);
            if (in_valid && in_ready) begin
                flanged_due.push_back(flange_mix(sample_in));
                n_taken++;
            end
        end
    end

    task automatic send(input logic [SAMPLE_W-1:0] s);
        samples_pending.push_back(s);
        n_queued++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait for every sample to be taken and every result to come back
    task automatic drain();
        while (n_taken != n_queued || flanged_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // main sequence
    initial begin
        logic [CFG_DATA_BITS-1:0] v;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings; first item sits at zero delay
        send('0);
        send(SAMPLE_MAX);
        send(12'h555);
        send(12'hAAA);
        drain();

        // widest sweep, fastest step, fully wet: climbs to the top of the sweep
        cfg_write(CFG_MIX_RATIO, '0);
        cfg_write(CFG_SWEEP_RANGE, 20'h01FFF);
        cfg_write(CFG_PHASE_STEP, 20'hFFFFF);
        for (int i = 0; i < 18; i++)
            send(i[0] ? SAMPLE_MAX : SAMPLE_W'(i * 229));
        drain();

        // frozen sweep, fully dry, no span
        cfg_write(CFG_MIX_RATIO, 20'h0FFFF);
        cfg_write(CFG_SWEEP_RANGE, '0);
        cfg_write(CFG_PHASE_STEP, '0);
        send(SAMPLE_MAX);
        send('0);
        send(12'h800);
        drain();

        // random phases with fresh settings each time
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 2))
                0:       v = '0;
                1:       v = 20'h0FFFF;
                default: v = CFG_DATA_BITS'($urandom);
            endcase
            cfg_write(CFG_MIX_RATIO, v);
            case ($urandom_range(0, 2))
                0:       v = '0;
                1:       v = 20'h01FFF;
                default: v = CFG_DATA_BITS'($urandom);
            endcase
            cfg_write(CFG_SWEEP_RANGE, v);
            case ($urandom_range(0, 4))
                0:       v = '0;
                1:       v = 20'hFFFFF;
                2:       v = CFG_DATA_BITS'($urandom_range(1, 4096));
                3:       v = CFG_DATA_BITS'($urandom_range(65536, 1048575));
                default: v = CFG_DATA_BITS'($urandom);
            endcase
            cfg_write(CFG_PHASE_STEP, v);
            // spare index must leave everything alone
            if ($urandom_range(0, 2) == 0)
                cfg_write(CFG_SPARE, CFG_DATA_BITS'($urandom));
            in_idle_en  = $urandom_range(0, 3) != 0;
            out_idle_en = $urandom_range(0, 3) != 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send(rand_sample());
            drain();
        end

        if (n_err == 0)
            $display("PASS audio_flanger_delay_top");
        else
            $display("FAIL audio_flanger_delay_top");
        $finish;
    end

    // watchdog
    initial begin
        #(2_000_000);
        $display("FAIL audio_flanger_delay_top");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/afl_pkg.sv
hw/rtl/afl_ctrl.sv
hw/rtl/afl_datapath.sv
hw/rtl/audio_flanger_delay_top.sv
hw/rtl/afl_checker.sv
dv/tb_audio_flanger_delay_top.sv
